[hw/rtl/dense_graph_shortest_path_assert.svh]
// ----------------------------------------------------------------------------
// dense_graph_shortest_path_assert.svh
// assertion macros shared by the shortest path block
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATH_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DGSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgsp assertion failed");

// next-cycle implication, checked out of reset
`define DGSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgsp assertion failed");

`endif

[hw/rtl/dgsp_pkg.sv]
// ----------------------------------------------------------------------------
// dgsp_pkg
// types and constants of the dense graph shortest path block
// ----------------------------------------------------------------------------
package dgsp_pkg;

    localparam int DIST_W  = 35;
    localparam int LEN_W   = 31;
    localparam int TALLY_W = 16;
    localparam int EDGE_W  = 32;

    localparam logic [DIST_W-1:0] INT_LIMIT = DIST_W'(32'h7FFF_FFFF);

    // request modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_START  = 2'd1;
    localparam logic [1:0] CFG_FINISH = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_DIST     = 3'd0;
    localparam logic [2:0] KIND_UNREACH  = 3'd1;
    localparam logic [2:0] KIND_BIG      = 3'd2;
    localparam logic [2:0] KIND_PATH     = 3'd3;
    localparam logic [2:0] KIND_NOPATH   = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_INIT,
        ST_INIT_FIN,
        ST_SCAN,
        ST_RELAX,
        ST_EMIT,
        ST_PATH_RD,
        ST_PATH_OUT
    } state_t;

endpackage

[hw/rtl/dense_graph_shortest_path.sv]
// ----------------------------------------------------------------------------
// dense_graph_shortest_path
// single source shortest paths over an adjacency memory
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. mode selects
// add edge (stored both ways), clear all edges (one entry a cycle over all
// MAX_VERTICES^2 entries) or run. A run gives one distance result per
// vertex in use, then the path from finish back to start, or a no-path or an
// overflow mark. Each result shows for one cycle under result_valid; last
// marks the final one of a run. The receiver cannot stall: results go out
// as they are made.
// A run first resets all MAX_VERTICES vertex records and counts the edges of
// the start vertex, then for each settled vertex makes a scan pass and a
// relax pass over the vertex memory and the edge memory (one read port each),
// then gives the distance results and the path results or mark.
// Reset runs a clearing pass over all MAX_VERTICES^2 entries of the edge
// memory with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path
    import dgsp_pkg::*;
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [4:0]         edge_from,
    input  logic [4:0]         edge_to,
    input  logic [LEN_W-1:0]   edge_length,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    output logic               result_valid,
    output logic [2:0]         kind,
    output logic [4:0]         vertex,
    output logic [DIST_W-1:0]  distance,
    output logic               last
);

`include "dense_graph_shortest_path_assert.svh"

    localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW  = IW + 1;
    localparam int PW  = $clog2(MAX_VERTICES + 1);
    localparam int AW  = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int EDEPTH = MAX_VERTICES * MAX_VERTICES;

    typedef struct packed {
        logic               unreach;
        logic [DIST_W-1:0]  dval;
        logic [PW-1:0]      pred;
        logic [TALLY_W-1:0] tally;
    } vrec_t;

    // registers
    state_t             state_reg, state_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [NW-1:0]      k_reg, k_next;
    logic [IW-1:0]      pick_reg, pick_next;
    logic               pick_ok_reg, pick_ok_next;
    logic [DIST_W-1:0]  pick_dist_reg, pick_dist_next;
    logic [TALLY_W-1:0] pick_tally_reg, pick_tally_next;
    logic [MAX_VERTICES-1:0] settled_reg, settled_next;
    logic [TALLY_W-1:0] tcnt_reg, tcnt_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0]      pipe_idx_reg, pipe_idx_next;
    logic [4:0]         vc_reg, sv_reg, fv_reg;
    logic [IW-1:0]      ea_reg, ea_next, eb_reg, eb_next;
    logic [LEN_W-1:0]   elen_reg, elen_next;
    logic [IW-1:0]      pv_reg, pv_next;
    logic [NW-1:0]      steps_reg, steps_next;
    logic               first_reg, first_next;
    logic               rv_reg, rv_next;
    logic [2:0]         kind_reg, kind_next;
    logic [4:0]         vtx_reg, vtx_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic               last_reg, last_next;

    // memories
    logic [EDGE_W-1:0]  edge_mem [EDEPTH];
    logic [EDGE_W-1:0]  erd_reg;
    logic               em_we;
    logic [AW-1:0]      em_wa, em_ra;
    logic [EDGE_W-1:0]  em_wd;
    vrec_t              vmem [MAX_VERTICES];
    vrec_t              vrd_reg;
    logic               vm_we;
    logic [IW-1:0]      vm_wa, vm_ra;
    vrec_t              vm_wd;

    // derived values
    logic               accept;
    logic [NW-1:0]      n_eff;
    logic [IW-1:0]      s_idx, f_idx;
    logic [NW-1:0]      sweep_lim;
    logic               issue, sweep_end, clr_end, edge_ok;
    logic [DIST_W-1:0]  cand;
    logic               take, relax_wr;
    logic               mark_out;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // effective vertex count, start and finish
    always_comb
    begin
        if (vc_reg == 5'd0)
            n_eff = NW'(1);
        else if ({1'b0, vc_reg} > 6'(MAX_VERTICES))
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(vc_reg);
        if (sv_reg == 5'd0)
            s_idx = '0;
        else if (6'(sv_reg) > 6'(n_eff))
            s_idx = IW'(n_eff - NW'(1));
        else
            s_idx = IW'(sv_reg - 5'd1);
        if (fv_reg == 5'd0)
            f_idx = '0;
        else if (6'(fv_reg) > 6'(n_eff))
            f_idx = IW'(n_eff - NW'(1));
        else
            f_idx = IW'(fv_reg - 5'd1);
    end

    assign edge_ok = (edge_from != 5'd0) && (6'(edge_from) <= 6'(n_eff))
                  && (edge_to != 5'd0) && (6'(edge_to) <= 6'(n_eff));

    // sweep counter control
    assign sweep_lim = (state_reg == ST_INIT) ? NW'(MAX_VERTICES) : n_eff;
    assign issue     = ((state_reg == ST_INIT) || (state_reg == ST_SCAN)
                     || (state_reg == ST_RELAX) || (state_reg == ST_EMIT))
                     && (cnt_reg < sweep_lim);
    assign sweep_end = (cnt_reg == sweep_lim);
    assign clr_end   = (clr_reg == AW'(EDEPTH - 1));

    // scan and relax decisions on returned data
    assign take = pipe_vld_reg && !settled_reg[pipe_idx_reg] && !vrd_reg.unreach
               && (!pick_ok_reg || (vrd_reg.dval < pick_dist_reg));
    assign cand = pick_dist_reg + DIST_W'(erd_reg[LEN_W-1:0]);
    assign relax_wr = pipe_vld_reg && (pipe_idx_reg != pick_reg) && erd_reg[EDGE_W-1]
                   && (vrd_reg.unreach || (cand < vrd_reg.dval));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_end)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ADD:   state_next = edge_ok ? ST_EDGE2 : ST_IDLE;
                        MODE_RUN:   state_next = ST_INIT;
                        MODE_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE2:    state_next = ST_IDLE;
            ST_INIT:
            begin
                if (sweep_end)
                    state_next = ST_INIT_FIN;
            end
            ST_INIT_FIN: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sweep_end)
                    state_next = (pick_ok_reg || take) ? ST_RELAX : ST_EMIT;
            end
            ST_RELAX:
            begin
                if (sweep_end)
                    state_next = (k_reg + NW'(1) == n_eff) ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT:
            begin
                if (sweep_end)
                    state_next = ST_PATH_RD;
            end
            ST_PATH_RD:  state_next = ST_PATH_OUT;
            ST_PATH_OUT:
            begin
                if (first_reg && (vrd_reg.pred == '0) && (f_idx != s_idx))
                    state_next = ST_IDLE;
                else if (first_reg && (vrd_reg.tally > TALLY_W'(1)) && !vrd_reg.unreach
                         && (vrd_reg.dval > INT_LIMIT))
                    state_next = ST_IDLE;
                else if ((vrd_reg.pred != '0) && (steps_reg + NW'(1) < n_eff))
                    state_next = ST_PATH_RD;
                else
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath, memory ports and results
    always_comb
    begin
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        k_next          = k_reg;
        pick_next       = pick_reg;
        pick_ok_next    = pick_ok_reg;
        pick_dist_next  = pick_dist_reg;
        pick_tally_next = pick_tally_reg;
        settled_next    = settled_reg;
        tcnt_next       = tcnt_reg;
        pipe_vld_next   = issue;
        pipe_idx_next   = IW'(cnt_reg);
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        elen_next       = elen_reg;
        pv_next         = pv_reg;
        steps_next      = steps_reg;
        first_next      = first_reg;
        rv_next         = 1'b0;
        kind_next       = KIND_DIST;
        vtx_next        = 5'd0;
        dist_next       = '0;
        last_next       = 1'b0;
        em_we           = 1'b0;
        em_wa           = clr_reg;
        em_wd           = '0;
        em_ra           = AW'(s_idx) * AW'(MAX_VERTICES) + AW'(cnt_reg);
        vm_we           = 1'b0;
        vm_wa           = IW'(cnt_reg);
        vm_wd           = vrd_reg;
        vm_ra           = IW'(cnt_reg);

        if (issue)
            cnt_next = cnt_reg + NW'(1);

        case (state_reg)
            // sweep the edge memory to no edge
            ST_CLEAR:
            begin
                em_we    = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            // take a request
            ST_IDLE:
            begin
                cnt_next = '0;
                clr_next = '0;
                if (accept && (mode == MODE_ADD) && edge_ok)
                begin
                    em_we     = 1'b1;
                    em_wa     = AW'(edge_from - 5'd1) * AW'(MAX_VERTICES)
                              + AW'(edge_to - 5'd1);
                    em_wd     = {1'b1, edge_length};
                    ea_next   = IW'(edge_from - 5'd1);
                    eb_next   = IW'(edge_to - 5'd1);
                    elen_next = edge_length;
                end
                tcnt_next = '0;
            end
            // mirror entry of the new edge
            ST_EDGE2:
            begin
                em_we = 1'b1;
                em_wa = AW'(eb_reg) * AW'(MAX_VERTICES) + AW'(ea_reg);
                em_wd = {1'b1, elen_reg};
            end
            // reset vertex records, count start edges
            ST_INIT:
            begin
                if (issue)
                begin
                    vm_we       = 1'b1;
                    vm_wd       = '0;
                    vm_wd.unreach = 1'b1;
                end
                if (pipe_vld_reg && (NW'(pipe_idx_reg) < n_eff) && erd_reg[EDGE_W-1])
                    tcnt_next = tcnt_reg + TALLY_W'(1);
            end
            // seed the start vertex
            ST_INIT_FIN:
            begin
                vm_we        = 1'b1;
                vm_wa        = s_idx;
                vm_wd        = '0;
                vm_wd.tally  = tcnt_reg;
                settled_next = '0;
                k_next       = '0;
                cnt_next     = '0;
                pick_ok_next = 1'b0;
            end
            // find the closest unsettled vertex
            ST_SCAN:
            begin
                if (take)
                begin
                    pick_ok_next    = 1'b1;
                    pick_next       = pipe_idx_reg;
                    pick_dist_next  = vrd_reg.dval;
                    pick_tally_next = vrd_reg.tally;
                end
                if (sweep_end)
                    cnt_next = '0;
            end
            // relax the neighbors of the picked vertex
            ST_RELAX:
            begin
                em_ra = AW'(pick_reg) * AW'(MAX_VERTICES) + AW'(cnt_reg);
                if (relax_wr)
                begin
                    vm_we         = 1'b1;
                    vm_wa         = pipe_idx_reg;
                    vm_wd.unreach = 1'b0;
                    vm_wd.dval    = cand;
                    vm_wd.pred    = PW'(pick_reg) + PW'(1);
                    vm_wd.tally   = vrd_reg.tally + pick_tally_reg;
                end
                if (sweep_end)
                begin
                    settled_next[pick_reg] = 1'b1;
                    k_next       = k_reg + NW'(1);
                    cnt_next     = '0;
                    pick_ok_next = 1'b0;
                end
            end
            // one distance result per vertex
            ST_EMIT:
            begin
                if (pipe_vld_reg)
                begin
                    rv_next  = 1'b1;
                    vtx_next = 5'(pipe_idx_reg) + 5'd1;
                    if (vrd_reg.unreach)
                        kind_next = KIND_UNREACH;
                    else if (vrd_reg.dval > INT_LIMIT)
                        kind_next = KIND_BIG;
                    else
                    begin
                        kind_next = KIND_DIST;
                        dist_next = vrd_reg.dval;
                    end
                end
                pv_next    = f_idx;
                steps_next = '0;
                first_next = 1'b1;
            end
            ST_PATH_RD:
            begin
                vm_ra = pv_reg;
            end
            // walk the predecessor chain
            ST_PATH_OUT:
            begin
                rv_next    = 1'b1;
                first_next = 1'b0;
                if (first_reg && (vrd_reg.pred == '0) && (f_idx != s_idx))
                begin
                    kind_next = KIND_NOPATH;
                    vtx_next  = 5'(f_idx) + 5'd1;
                    last_next = 1'b1;
                end
                else if (first_reg && (vrd_reg.tally > TALLY_W'(1)) && !vrd_reg.unreach
                         && (vrd_reg.dval > INT_LIMIT))
                begin
                    kind_next = KIND_OVERFLOW;
                    vtx_next  = 5'(f_idx) + 5'd1;
                    last_next = 1'b1;
                end
                else if ((vrd_reg.pred != '0) && (steps_reg + NW'(1) < n_eff))
                begin
                    kind_next  = KIND_PATH;
                    vtx_next   = 5'(pv_reg) + 5'd1;
                    pv_next    = IW'(vrd_reg.pred - PW'(1));
                    steps_next = steps_reg + NW'(1);
                end
                else
                begin
                    kind_next = KIND_PATH;
                    vtx_next  = 5'(pv_reg) + 5'd1;
                    last_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            k_reg        <= '0;
            pick_ok_reg  <= 1'b0;
            settled_reg  <= '0;
            pipe_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
            rv_reg       <= 1'b0;
            vc_reg       <= 5'd16;
            sv_reg       <= 5'd1;
            fv_reg       <= 5'd1;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_reg      <= clr_next;
            k_reg        <= k_next;
            pick_ok_reg  <= pick_ok_next;
            settled_reg  <= settled_next;
            pipe_vld_reg <= pipe_vld_next;
            first_reg    <= first_next;
            rv_reg       <= rv_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COUNT:  vc_reg <= cfg_data;
                    CFG_START:  sv_reg <= cfg_data;
                    CFG_FINISH: fv_reg <= cfg_data;
                    default:    vc_reg <= vc_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        pick_dist_reg  <= pick_dist_next;
        pick_tally_reg <= pick_tally_next;
        tcnt_reg       <= tcnt_next;
        pipe_idx_reg   <= pipe_idx_next;
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        elen_reg       <= elen_next;
        pv_reg         <= pv_next;
        steps_reg      <= steps_next;
        kind_reg       <= kind_next;
        vtx_reg        <= vtx_next;
        dist_reg       <= dist_next;
        last_reg       <= last_next;
    end

    // edge memory
    always_ff @(posedge clk)
    begin
        if (em_we)
            edge_mem[em_wa] <= em_wd;
        erd_reg <= edge_mem[em_ra];
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (vm_we)
            vmem[vm_wa] <= vm_wd;
        vrd_reg <= vmem[vm_ra];
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign vertex       = vtx_reg;
    assign distance     = dist_reg;
    assign last         = last_reg && rv_reg;

    // no-path and overflow marks on the result port
    assign mark_out = result_valid
                   && ((kind == KIND_NOPATH) || (kind == KIND_OVERFLOW));

    // checks
    `DGSP_ASSERT_NEXT(a_run_goes_busy, start && !busy && (mode == MODE_RUN), busy)
    `DGSP_ASSERT_NEXT(a_nothing_after_last, result_valid && last, !result_valid)
    `DGSP_ASSERT_NOW(a_mark_is_last, mark_out, last)

endmodule

[test/tb_dense_graph_shortest_path.sv]
// ----------------------------------------------------------------------------
// tb_dense_graph_shortest_path
// self-checking testbench of the dense graph shortest path block
// ----------------------------------------------------------------------------
// Edges, clears and runs go in as requests. Every accepted request also goes
// to an in-bench model of the adjacency store and of the search. The model
// queues the results that a run must give, and a checker compares each result
// strobe field by field with the oldest one. A directed part covers the
// configuration extremes, the edge length extremes, self loops, dropped and
// replaced edges, no path and overflow. A random part follows, in phases with
// new settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_dense_graph_shortest_path;
    import dgsp_pkg::*;

    localparam int NV = 16;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic [2:0]        kind;
        logic [4:0]        vertex;
        logic [DIST_W-1:0] distance;
        logic              last;
    } result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        mode = MODE_ADD;
    logic [4:0]        edge_from = '0;
    logic [4:0]        edge_to = '0;
    logic [LEN_W-1:0]  edge_length = '0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = CFG_COUNT;
    logic [4:0]        cfg_data = '0;
    logic              result_valid;
    logic [2:0]        kind;
    logic [4:0]        vertex;
    logic [DIST_W-1:0] distance;
    logic              last;

    // model of the adjacency store and the registers
    logic             adj_on [NV*NV];
    logic [LEN_W-1:0] adj_len [NV*NV];
    logic [4:0]       reg_count = 5'd16;
    logic [4:0]       reg_start = 5'd1;
    logic [4:0]       reg_finish = 5'd1;

    result_t pending_results[$];
    int      err_count = 0;
    int      items_sent = 0;
    bit      quiet = 1'b0;

    dense_graph_shortest_path u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .edge_from(edge_from), .edge_to(edge_to), .edge_length(edge_length),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .kind(kind), .vertex(vertex),
        .distance(distance), .last(last)
    );

    always #1 clk = ~clk;

    function automatic int count_in_use();
        if (reg_count < 1) return 1;
        if (reg_count > NV) return NV;
        return int'(reg_count);
    endfunction

    function automatic int vertex_index(logic [4:0] v, int n);
        if (v < 1) return 0;
        if (v > n) return n - 1;
        return int'(v) - 1;
    endfunction

    function automatic void push_result(logic [2:0] k, int v, logic [DIST_W-1:0] d);
        result_t r;
        r.kind = k;
        r.vertex = 5'(v);
        r.distance = d;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // shortest path search and the results it gives
    function automatic void predict_search();
        int            n;
        int            s;
        int            f;
        int            pick;
        int            v;
        int            steps;
        logic [35:0]   best [NV];
        logic          unreach [NV];
        logic          done [NV];
        int            pred [NV];
        logic [15:0]   tally [NV];
        logic [35:0]   cand;
        result_t       r;
        n = count_in_use();
        s = vertex_index(reg_start, n);
        f = vertex_index(reg_finish, n);
        for (int i = 0; i < NV; i++)
        begin
            best[i] = '0; unreach[i] = 1'b1; done[i] = 1'b0; pred[i] = 0; tally[i] = '0;
        end
        unreach[s] = 1'b0;
        for (int i = 0; i < n; i++)
            if (adj_on[s*NV+i]) tally[s] = tally[s] + 16'd1;
        for (int k = 0; k < n; k++)
        begin
            pick = -1;
            for (int i = 0; i < n; i++)
                if (!done[i] && !unreach[i] && (pick < 0 || best[i] < best[pick]))
                    pick = i;
            if (pick < 0) break;
            for (int i = 0; i < n; i++)
            begin
                if (i == pick || !adj_on[pick*NV+i]) continue;
                cand = best[pick] + 36'(adj_len[pick*NV+i]);
                if (unreach[i] || cand < best[i])
                begin
                    best[i] = cand;
                    unreach[i] = 1'b0;
                    pred[i] = pick + 1;
                    tally[i] = tally[i] + tally[pick];
                end
            end
            done[pick] = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (unreach[i]) push_result(KIND_UNREACH, i + 1, '0);
            else if (best[i] > 36'(INT_LIMIT)) push_result(KIND_BIG, i + 1, '0);
            else push_result(KIND_DIST, i + 1, best[i][DIST_W-1:0]);
        end
        if (pred[f] == 0 && f != s)
            push_result(KIND_NOPATH, f + 1, '0);
        else if (tally[f] > 1 && !unreach[f] && best[f] > 36'(INT_LIMIT))
            push_result(KIND_OVERFLOW, f + 1, '0);
        else
        begin
            v = f;
            steps = 0;
            while (pred[v] != 0 && steps + 1 < n)
            begin
                push_result(KIND_PATH, v + 1, '0);
                v = (pred[v] - 1) % NV;
                steps++;
            end
            push_result(KIND_PATH, v + 1, '0);
        end
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    // model update for one accepted request
    function automatic void apply_request(logic [1:0] m, logic [4:0] a, logic [4:0] b,
                                          logic [LEN_W-1:0] len);
        int n;
        n = count_in_use();
        if (m == MODE_ADD)
        begin
            if (a >= 1 && a <= n && b >= 1 && b <= n)
            begin
                adj_on[(a-1)*NV+(b-1)] = 1'b1; adj_len[(a-1)*NV+(b-1)] = len;
                adj_on[(b-1)*NV+(a-1)] = 1'b1; adj_len[(b-1)*NV+(a-1)] = len;
            end
        end
        else if (m == MODE_RUN)
            predict_search();
        else if (m == MODE_CLEAR)
            for (int i = 0; i < NV*NV; i++) adj_on[i] = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [DIST_W-1:0] got,
                                   logic [DIST_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, kind", DIST_W'(kind), '0);
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind) report_mismatch("kind", DIST_W'(kind), DIST_W'(want.kind));
                if (vertex !== want.vertex)
                    report_mismatch("vertex", DIST_W'(vertex), DIST_W'(want.vertex));
                if (distance !== want.distance) report_mismatch("distance", distance, want.distance);
                if (last !== want.last) report_mismatch("last", DIST_W'(last), DIST_W'(want.last));
            end
        end
    end

    // one request, held until accepted
    task automatic send_request(logic [1:0] m, logic [4:0] a, logic [4:0] b,
                                logic [LEN_W-1:0] len);
        start <= 1'b1;
        mode <= m;
        edge_from <= a;
        edge_to <= b;
        edge_length <= len;
        do @(posedge clk); while (busy);
        apply_request(m, a, b, len);
        items_sent++;
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic add_edge(int a, int b, logic [LEN_W-1:0] len);
        send_request(MODE_ADD, 5'(a), 5'(b), len);
        maybe_pause();
    endtask

    task automatic run_search();
        send_request(MODE_RUN, 5'($urandom), 5'($urandom), LEN_W'($urandom));
        maybe_pause();
    endtask

    task automatic clear_edges();
        send_request(MODE_CLEAR, 5'($urandom), 5'($urandom), LEN_W'($urandom));
        maybe_pause();
    endtask

    // block idle: no result outstanding and no request in work
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // one register write strobe, followed by a pause on the write port
    task automatic write_register(logic [1:0] idx, logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COUNT) reg_count = val;
        else if (idx == CFG_START) reg_start = val;
        else if (idx == CFG_FINISH) reg_finish = val;
        @(posedge clk);
    endtask

    task automatic set_graph(logic [4:0] n, logic [4:0] s, logic [4:0] f);
        drain();
        write_register(CFG_COUNT, n);
        write_register(CFG_START, s);
        write_register(CFG_FINISH, f);
    endtask

    task automatic test_reset_state();
        run_search();
        send_request(MODE_SPARE, 5'd31, 5'd31, LEN_MAX);
        maybe_pause();
        run_search();
    endtask

    task automatic test_overflow();
        // two equal shortest paths above the int limit
        set_graph(5'd4, 5'd1, 5'd3);
        add_edge(1, 2, LEN_MAX);
        add_edge(1, 4, LEN_MAX);
        add_edge(2, 3, LEN_MAX);
        add_edge(4, 3, LEN_MAX);
        run_search();
        // single path above the int limit
        clear_edges();
        add_edge(1, 2, LEN_MAX);
        add_edge(2, 3, LEN_MAX);
        run_search();
    endtask

    task automatic test_edge_cases();
        // count 0, start and finish 0
        set_graph(5'd0, 5'd0, 5'd0);
        add_edge(1, 1, 31'd5);
        run_search();
        // count above range, start and finish out of range, dropped and replaced edges
        set_graph(5'd31, 5'd31, 5'd31);
        clear_edges();
        add_edge(0, 3, 31'd1);
        add_edge(17, 2, 31'd1);
        add_edge(16, 31, 31'd1);
        add_edge(16, 15, 31'd0);
        add_edge(15, 14, 31'd9);
        add_edge(14, 15, 31'd2);
        add_edge(16, 16, 31'd0);
        run_search();
        // reduced count hides stored edges, finish unreachable
        set_graph(5'd14, 5'd1, 5'd14);
        run_search();
    endtask

    task automatic test_random();
        int n;
        int a;
        int b;
        int runs;
        logic [LEN_W-1:0] len;
        while (items_sent < 420)
        begin
            if (items_sent > 360) quiet = 1'b1;
            case ($urandom_range(0, 4))
                0: n = 1;
                1: n = 16;
                default: n = $urandom_range(2, 8);
            endcase
            set_graph(5'(n), ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, n)),
                      ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, n)));
            if ($urandom_range(0, 1)) clear_edges();
            repeat ($urandom_range(1, 3 * n))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    a = $urandom_range(0, 31); b = $urandom_range(0, 31);
                end
                else
                begin
                    a = $urandom_range(1, n); b = $urandom_range(1, n);
                end
                case ($urandom_range(0, 5))
                    0: len = LEN_MAX;
                    1: len = LEN_W'($urandom);
                    2: len = LEN_MAX - LEN_W'($urandom_range(0, 1000));
                    default: len = LEN_W'($urandom_range(0, 20));
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    send_request(MODE_SPARE, 5'($urandom), 5'($urandom), LEN_W'($urandom));
                    maybe_pause();
                end
                else
                    add_edge(a, b, len);
            end
            runs = $urandom_range(1, 3);
            repeat (runs) run_search();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_overflow();
        test_edge_cases();
        test_random();
        drain();
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < NV*NV; i++)
        begin
            adj_on[i] = 1'b0;
            adj_len[i] = '0;
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/dgsp_pkg.sv
hw/rtl/dense_graph_shortest_path.sv
test/tb_dense_graph_shortest_path.sv
